>>> hdl/move_to_front_queue_macros.svh
// Assertion macros for the move-to-front queue RTL.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MOVE_TO_FRONT_QUEUE_MACROS_SVH
`define MOVE_TO_FRONT_QUEUE_MACROS_SVH

// same-cycle implication
`define MTFQ_AST_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mtfq check failed");

// next-cycle implication
`define MTFQ_AST_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mtfq check failed");

`endif

>>> hdl/mtfq_pkg.sv
// Package for the move-to-front queue: sizes, codes, control structs, address helper.
// No dependencies.
package mtfq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PORT_VAL_W  = 32;
  localparam int PORT_CNT_W  = 5;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int SUM_W       = CNT_W + 1;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_MOVE    = 2'd2,
    ACT_PEEK    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT_KEY,
    ST_FRONT_RD,
    ST_REPORT
  } state_e;

  // logical offset fed to the shared address adder
  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_COUNT,
    OFF_IDX,
    OFF_IDX_M1
  } off_sel_e;

  typedef enum logic [1:0] {
    WD_INPUT,
    WD_RDATA,
    WD_KEY
  } wd_sel_e;

  typedef struct packed {
    logic     latch;
    off_sel_e off_sel;
    wd_sel_e  wd_sel;
    logic     mem_we;
    logic     mem_re;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     head_inc;
    logic     idx_clr;
    logic     idx_inc;
    logic     idx_dec;
    logic     st_load;
    status_e  st_val;
    logic     res_load;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic idx_zero;
    logic idx_one;
    logic idx_last;
  } flg_t;

  // physical slot of logical position off, ring starting at base
  function automatic idx_t wrap_add(idx_t base, cnt_t off);
    sum_t s;
    s = sum_t'(base) + sum_t'(off);
    if (s >= sum_t'(CAPACITY)) s = s - sum_t'(CAPACITY);
    return idx_t'(s);
  endfunction

endpackage

>>> hdl/mtfq_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mtfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mtfq_seq.sv
// Sequencer of the move-to-front queue: state machine issuing datapath commands.
// Depends on mtfq_pkg.
module mtfq_seq
  import mtfq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] action_i,
  input  flg_t       flg_i,
  output ctl_t       ctl_o,
  output logic       busy_o
);

  state_e  state_q, state_d;
  action_e act;

  assign act    = action_e'(action_i);
  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (act == ACT_MOVE && !flg_i.empty) state_d = ST_SRCH_RD;
          else state_d = ST_FRONT_RD;
        end
      end
      ST_SRCH_RD: state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (flg_i.hit) state_d = flg_i.idx_zero ? ST_FRONT_RD : ST_SHIFT_RD;
        else if (flg_i.idx_last) state_d = ST_FRONT_RD;
        else state_d = ST_SRCH_RD;
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = flg_i.idx_one ? ST_PUT_KEY : ST_SHIFT_RD;
      ST_PUT_KEY:  state_d = ST_FRONT_RD;
      ST_FRONT_RD: state_d = ST_REPORT;
      ST_REPORT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl_o         = '0;
    ctl_o.off_sel = OFF_ZERO;
    ctl_o.wd_sel  = WD_INPUT;
    ctl_o.st_val  = STS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.latch   = 1'b1;
          ctl_o.st_load = 1'b1;
          unique case (act)
            ACT_ENQUEUE: begin
              if (flg_i.full) begin
                ctl_o.st_val = STS_FULL;
              end else begin
                ctl_o.mem_we  = 1'b1;
                ctl_o.off_sel = OFF_COUNT;
                ctl_o.wd_sel  = WD_INPUT;
                ctl_o.cnt_inc = 1'b1;
              end
            end
            ACT_DEQUEUE: begin
              if (flg_i.empty) begin
                ctl_o.st_val = STS_EMPTY;
              end else begin
                ctl_o.head_inc = 1'b1;
                ctl_o.cnt_dec  = 1'b1;
              end
            end
            ACT_MOVE: begin
              ctl_o.st_val  = flg_i.empty ? STS_EMPTY : STS_OK;
              ctl_o.idx_clr = 1'b1;
            end
            ACT_PEEK: ctl_o.st_val = flg_i.empty ? STS_EMPTY : STS_OK;
            default:  ctl_o.st_val = STS_OK;
          endcase
        end
      end
      ST_SRCH_RD: begin
        ctl_o.mem_re  = 1'b1;
        ctl_o.off_sel = OFF_IDX;
      end
      ST_SRCH_CMP: begin
        if (!flg_i.hit) begin
          if (flg_i.idx_last) begin
            ctl_o.st_load = 1'b1;
            ctl_o.st_val  = STS_NOT_FOUND;
          end else begin
            ctl_o.idx_inc = 1'b1;
          end
        end
      end
      ST_SHIFT_RD: begin
        ctl_o.mem_re  = 1'b1;
        ctl_o.off_sel = OFF_IDX_M1;
      end
      ST_SHIFT_WR: begin
        ctl_o.mem_we  = 1'b1;
        ctl_o.off_sel = OFF_IDX;
        ctl_o.wd_sel  = WD_RDATA;
        ctl_o.idx_dec = 1'b1;
      end
      ST_PUT_KEY: begin
        ctl_o.mem_we  = 1'b1;
        ctl_o.off_sel = OFF_ZERO;
        ctl_o.wd_sel  = WD_KEY;
      end
      ST_FRONT_RD: begin
        ctl_o.mem_re  = 1'b1;
        ctl_o.off_sel = OFF_ZERO;
      end
      ST_REPORT: ctl_o.res_load = 1'b1;
      default:   ctl_o.res_load = 1'b0;
    endcase
  end

endmodule

>>> hdl/mtfq_dp.sv
// Datapath of the move-to-front queue: ring pointers, shared address adder,
// key compare and the entry RAM. Depends on mtfq_pkg and mtfq_ram.
module mtfq_dp
  import mtfq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ctl_t    ctl_i,
  input  val_t    value_i,
  output flg_t    flg_o,
  output val_t    front_o,
  output cnt_t    count_o,
  output status_e status_o
);

  idx_t    head_q, head_d;
  cnt_t    count_q, count_d;
  idx_t    idx_q, idx_d;
  val_t    key_q, key_d;
  status_e status_q, status_d;
  cnt_t    off;
  idx_t    addr;
  val_t    wdata;
  val_t    rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      status_q <= STS_OK;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_comb begin
    head_d   = ctl_i.head_inc ? wrap_add(head_q, cnt_t'(1)) : head_q;
    count_d  = count_q;
    if (ctl_i.cnt_inc) count_d = count_q + cnt_t'(1);
    else if (ctl_i.cnt_dec) count_d = count_q - cnt_t'(1);
    idx_d    = idx_q;
    if (ctl_i.idx_clr) idx_d = '0;
    else if (ctl_i.idx_inc) idx_d = idx_q + idx_t'(1);
    else if (ctl_i.idx_dec) idx_d = idx_q - idx_t'(1);
    key_d    = ctl_i.latch ? value_i : key_q;
    status_d = ctl_i.st_load ? ctl_i.st_val : status_q;
  end

  // shared address unit: logical offset to ring slot
  always_comb begin
    unique case (ctl_i.off_sel)
      OFF_ZERO:   off = '0;
      OFF_COUNT:  off = count_q;
      OFF_IDX:    off = cnt_t'(idx_q);
      OFF_IDX_M1: off = cnt_t'(idx_q - idx_t'(1));
      default:    off = '0;
    endcase
  end

  assign addr = wrap_add(head_q, off);

  always_comb begin
    unique case (ctl_i.wd_sel)
      WD_INPUT: wdata = value_i;
      WD_RDATA: wdata = rdata;
      WD_KEY:   wdata = key_q;
      default:  wdata = value_i;
    endcase
  end

  mtfq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.mem_we),
    .re_i    (ctl_i.mem_re),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign flg_o.empty    = (count_q == '0);
  assign flg_o.full     = (count_q == cnt_t'(CAPACITY));
  assign flg_o.hit      = (rdata == key_q);
  assign flg_o.idx_zero = (idx_q == '0);
  assign flg_o.idx_one  = (idx_q == idx_t'(1));
  assign flg_o.idx_last = ((cnt_t'(idx_q) + cnt_t'(1)) == count_q);

  assign front_o  = (count_q == '0) ? '0 : rdata;
  assign count_o  = count_q;
  assign status_o = status_q;

endmodule

>>> hdl/move_to_front_queue.sv
// Move-to-front queue top level. Enqueue, dequeue, peek and a move on an empty queue
// read the front and report; a move searches from the front for the key and, on a hit
// behind the front, shifts the entries ahead of it back by one slot and writes the key at
// the front. busy is high until the done_o strobe, so a new item is taken only after the
// last is reported; the single-port entry RAM and the shared address adder serialize the steps.
// rst_ni clears the queue to empty; the receiver cannot stall a result.
`include "move_to_front_queue_macros.svh"

module move_to_front_queue
  import mtfq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] item_value_i,
  output logic        done_o,
  output logic [31:0] front_value_o,
  output logic [4:0]  entry_count_o,
  output logic [1:0]  status_o
);

  ctl_t    ctl;
  flg_t    flg;
  val_t    front;
  cnt_t    count;
  status_e status;

  // result register: one-cycle strobe, payload held until next report
  logic                  done_q;
  logic [PORT_VAL_W-1:0] front_q;
  logic [PORT_CNT_W-1:0] count_q;
  status_e               status_q;

  // sequencer walks search, shift-down and key write one RAM access at a time
  mtfq_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .flg_i    (flg),
    .ctl_o    (ctl),
    .busy_o   (busy)
  );

  // entries live in a ring; dequeue advances the head and lowers the count, moving no data
  mtfq_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .value_i  (val_t'(item_value_i)),
    .flg_o    (flg),
    .front_o  (front),
    .count_o  (count),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.res_load) begin
      front_q  <= PORT_VAL_W'(front);
      count_q  <= PORT_CNT_W'(count);
      status_q <= status;
    end
  end

  assign done_o        = done_q;
  assign front_value_o = front_q;
  assign entry_count_o = count_q;
  assign status_o      = status_q;

  // an accepted item makes the block busy on the next clock
  `MTFQ_AST_NEXT(a_accept_busy, start && !busy, busy)
  // the strobe comes exactly when the sequencer drops busy
  `MTFQ_AST_IMPL(a_done_on_fall, done_o, !busy && $past(busy))
  // a dropped enqueue reports a full store
  `MTFQ_AST_IMPL(a_full_count, done_o && status_o == STS_FULL,
                 entry_count_o == PORT_CNT_W'(CAPACITY))
  // an empty store reports zero at the front
  `MTFQ_AST_IMPL(a_empty_front, done_o && entry_count_o == '0, front_value_o == '0)
  // empty status only with nothing held
  `MTFQ_AST_IMPL(a_empty_count, done_o && status_o == STS_EMPTY, entry_count_o == '0)

endmodule
